FILE: src/cpeb_pkg.sv
// ----------------------------------------------------------------------------
// cpeb_pkg
// Shared types and codes for the class priority event backlog.
// ----------------------------------------------------------------------------
package cpeb_pkg;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_BEGIN  = 2'd1,
    OP_FINISH = 2'd2,
    OP_POP    = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_UNSUPPORTED = 3'd2,
    ST_EMPTY       = 3'd3,
    ST_CONFLICT    = 3'd4,
    ST_EXPIRED     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_NORMAL = 2'd1,
    KIND_STOP   = 2'd2,
    KIND_URGENT = 2'd3
  } kind_t;

  localparam logic [1:0] CLS_URGENT = 2'd0;
  localparam logic [1:0] CLS_STOP   = 2'd1;
  localparam logic [1:0] CLS_NORMAL = 2'd2;
  localparam logic [1:0] CLS_UNSUP  = 2'd3;

  localparam logic [31:0] MAX_AGE_RESET = 32'd1000;

  typedef struct packed {
    opcode_t     opcode;
    logic [1:0]  event_class;
    logic [31:0] payload;
    logic [7:0]  payload_length;
    logic [31:0] time_ms;
    logic        retry;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] out_payload;
    logic [7:0]  out_length;
    logic [31:0] out_received_ms;
    logic [1:0]  out_class;
  } res_t;

endpackage

FILE: src/class_priority_event_backlog.sv
// ----------------------------------------------------------------------------
// class_priority_event_backlog
// Strict priority backlog of jobs in three classes sharing one slot pool.
//
// Channel | Dir | Handshake                | Content
// --------+-----+--------------------------+-------------------------------
// in_     | in  | in_tvalid / in_tready    | tuser opcode, tdata job fields
// out_    | out | out_tvalid / out_tready  | tuser status, tdata job fields
// cfg_    | in  | cfg_valid / cfg_ready    | max_age_ms
//
// One transfer per cycle sustained while the result side does not stall; an
// item's result passes the input register, then the result register after
// the state update. The state update for one item is combinational logic on
// the backlog registers. Reset is synchronous, active low, and restores the
// full free stack and empty rings. A stalled result holds the pipe; the input
// register still takes a transfer once the result register frees up.
// ----------------------------------------------------------------------------
module class_priority_event_backlog
  import cpeb_pkg::*;
#(
  parameter int TOTAL_SLOTS     = 16,
  parameter int NONURGENT_SLOTS = 8,
  parameter int NORMAL_SLOTS    = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // event_class, payload, payload_length, time_ms, retry
  input  logic [1:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // out_payload, out_length, out_received_ms, out_class
  output logic [2:0]  out_tuser,  // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data    // max_age_ms
);

  req_t        in_req_r;
  logic        in_valid_r;
  res_t        out_res_r;
  logic        out_valid_r;
  logic [31:0] max_age_r;
  res_t        res;
  logic        fire;

  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      max_age_r   <= MAX_AGE_RESET;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) max_age_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_req_r.opcode         <= opcode_t'(in_tuser);
      in_req_r.event_class    <= in_tdata[1:0];
      in_req_r.payload        <= in_tdata[33:2];
      in_req_r.payload_length <= in_tdata[41:34];
      in_req_r.time_ms        <= in_tdata[73:42];
      in_req_r.retry          <= in_tdata[74];
    end
    if (fire) out_res_r <= res;
  end

  cpeb_core #(
    .TOTAL_SLOTS    (TOTAL_SLOTS),
    .NONURGENT_SLOTS(NONURGENT_SLOTS),
    .NORMAL_SLOTS   (NORMAL_SLOTS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (fire),
    .req    (in_req_r),
    .max_age(max_age_r),
    .res    (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {6'd0, out_res_r.out_class, out_res_r.out_received_ms,
                       out_res_r.out_length, out_res_r.out_payload};

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !fire |=> in_valid_r && $stable(in_req_r))
    else $error("pending item lost while stalled");

  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed item gave no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> !out_valid_r || out_tready)
    else $error("result register overwritten while held");

endmodule

FILE: src/cpeb_core.sv
// ----------------------------------------------------------------------------
// cpeb_core
// Backlog state (slot pool, free stack, class rings, dispatch) and the
// combinational update for one operation.
// ----------------------------------------------------------------------------
module cpeb_core
  import cpeb_pkg::*;
#(
  parameter int TOTAL_SLOTS     = 16,
  parameter int NONURGENT_SLOTS = 8,
  parameter int NORMAL_SLOTS    = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  req_t        req,
  input  logic [31:0] max_age,
  output res_t        res
);

  localparam int SW  = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
  localparam int TCW = $clog2(TOTAL_SLOTS + 1);
  localparam int SIW = (NONURGENT_SLOTS > 1) ? $clog2(NONURGENT_SLOTS) : 1;
  localparam int SCW = $clog2(NONURGENT_SLOTS + 1);
  localparam int NIW = (NORMAL_SLOTS > 1) ? $clog2(NORMAL_SLOTS) : 1;
  localparam int NCW = $clog2(NORMAL_SLOTS + 1);
  localparam int NUW = $clog2(NONURGENT_SLOTS + NORMAL_SLOTS + 2);
  localparam int NRW = $clog2(NORMAL_SLOTS + 2);

  logic [31:0]    slot_payload [TOTAL_SLOTS];
  logic [7:0]     slot_length  [TOTAL_SLOTS];
  logic [31:0]    slot_time    [TOTAL_SLOTS];
  logic [SW-1:0]  free_stack_r [TOTAL_SLOTS];
  logic [SW-1:0]  urgent_ring  [TOTAL_SLOTS];
  logic [SW-1:0]  stop_ring    [NONURGENT_SLOTS];
  logic [SW-1:0]  normal_ring  [NORMAL_SLOTS];

  logic [TCW-1:0] free_depth_r, free_depth_nxt;
  logic [SW-1:0]  urg_rptr_r, urg_rptr_nxt;
  logic [TCW-1:0] urgent_count_r, urgent_count_nxt;
  logic [SIW-1:0] stp_rptr_r, stp_rptr_nxt;
  logic [SCW-1:0] stop_count_r, stop_count_nxt;
  logic [NIW-1:0] nrm_rptr_r, nrm_rptr_nxt;
  logic [NCW-1:0] normal_count_r, normal_count_nxt;
  logic [TCW-1:0] total_count_r, total_count_nxt;
  logic           busy_r, busy_nxt;
  kind_t          dkind_r, dkind_nxt;
  logic [SW-1:0]  dslot_r, dslot_nxt;

  // write controls
  logic           slot_we;
  logic [SW-1:0]  slot_wa;
  logic           fs_we;
  logic [SW-1:0]  fs_wa;
  logic [SW-1:0]  fs_wd;
  logic           u_we, s_we, n_we;
  logic [SW-1:0]  u_wa;
  logic [SIW-1:0] s_wa;
  logic [NIW-1:0] n_wa;
  logic [SW-1:0]  ring_wd;

  // operation decode
  logic           do_free, do_enq;
  logic [SW-1:0]  free_slot;
  kind_t          enq_kind;
  logic [SW-1:0]  enq_slot;
  logic           push_ok;

  kind_t          push_kind;
  logic [NUW-1:0] nonurg;
  logic [NRW-1:0] normal_use;
  logic           full;
  logic [SW-1:0]  push_slot;
  logic [TCW-1:0] depth_dec;

  kind_t          sel_kind;
  logic [1:0]     sel_class;
  logic [SW-1:0]  sel_slot;
  logic           sel_any;
  logic [31:0]    age;
  logic           expired;

  logic [SW:0]    u_sum;
  logic [SIW:0]   s_sum;
  logic [NIW:0]   n_sum;
  logic [SW-1:0]  u_tail;
  logic [SIW-1:0] s_tail;
  logic [NIW-1:0] n_tail;

  always_comb begin
    case (req.event_class)
      CLS_URGENT: push_kind = KIND_URGENT;
      CLS_STOP:   push_kind = KIND_STOP;
      default:    push_kind = KIND_NORMAL;
    endcase
    nonurg = NUW'(stop_count_r) + NUW'(normal_count_r)
           + NUW'(busy_r && dkind_r != KIND_URGENT);
    normal_use = NRW'(normal_count_r) + NRW'(busy_r && dkind_r == KIND_NORMAL);
    full = (total_count_r >= TCW'(TOTAL_SLOTS)) || (free_depth_r == '0)
        || (push_kind != KIND_URGENT && nonurg >= NUW'(NONURGENT_SLOTS))
        || (push_kind == KIND_NORMAL && normal_use >= NRW'(NORMAL_SLOTS));
    depth_dec = free_depth_r - TCW'(1);
    push_slot = free_stack_r[depth_dec[SW-1:0]];
  end

  always_comb begin
    sel_any = 1'b1;
    if (urgent_count_r != '0) begin
      sel_kind  = KIND_URGENT;
      sel_class = CLS_URGENT;
      sel_slot  = urgent_ring[urg_rptr_r];
    end else if (stop_count_r != '0) begin
      sel_kind  = KIND_STOP;
      sel_class = CLS_STOP;
      sel_slot  = stop_ring[stp_rptr_r];
    end else if (normal_count_r != '0) begin
      sel_kind  = KIND_NORMAL;
      sel_class = CLS_NORMAL;
      sel_slot  = normal_ring[nrm_rptr_r];
    end else begin
      sel_any   = 1'b0;
      sel_kind  = KIND_NONE;
      sel_class = CLS_URGENT;
      sel_slot  = '0;
    end
    age     = req.time_ms - slot_time[sel_slot];
    expired = (sel_kind != KIND_URGENT) && (age > max_age);
  end

  // ring tails, modulo ring size
  always_comb begin
    u_sum  = (SW+1)'(urg_rptr_r) + (SW+1)'(urgent_count_r);
    u_tail = (u_sum >= (SW+1)'(TOTAL_SLOTS)) ?
             SW'(u_sum - (SW+1)'(TOTAL_SLOTS)) : SW'(u_sum);
    s_sum  = (SIW+1)'(stp_rptr_r) + (SIW+1)'(stop_count_r);
    s_tail = (s_sum >= (SIW+1)'(NONURGENT_SLOTS)) ?
             SIW'(s_sum - (SIW+1)'(NONURGENT_SLOTS)) : SIW'(s_sum);
    n_sum  = (NIW+1)'(nrm_rptr_r) + (NIW+1)'(normal_count_r);
    n_tail = (n_sum >= (NIW+1)'(NORMAL_SLOTS)) ?
             NIW'(n_sum - (NIW+1)'(NORMAL_SLOTS)) : NIW'(n_sum);
  end

  always_comb begin
    free_depth_nxt   = free_depth_r;
    urg_rptr_nxt     = urg_rptr_r;
    urgent_count_nxt = urgent_count_r;
    stp_rptr_nxt     = stp_rptr_r;
    stop_count_nxt   = stop_count_r;
    nrm_rptr_nxt     = nrm_rptr_r;
    normal_count_nxt = normal_count_r;
    total_count_nxt  = total_count_r;
    busy_nxt         = busy_r;
    dkind_nxt        = dkind_r;
    dslot_nxt        = dslot_r;
    slot_we   = 1'b0;
    slot_wa   = push_slot;
    fs_we     = 1'b0;
    fs_wa     = free_depth_r[SW-1:0];
    fs_wd     = '0;
    u_we      = 1'b0;
    s_we      = 1'b0;
    n_we      = 1'b0;
    u_wa      = u_tail;
    s_wa      = s_tail;
    n_wa      = n_tail;
    ring_wd   = '0;
    do_free   = 1'b0;
    free_slot = '0;
    do_enq    = 1'b0;
    enq_kind  = KIND_NONE;
    enq_slot  = '0;
    push_ok   = 1'b0;
    res        = '0;
    res.status = ST_OK;

    case (req.opcode)
      OP_PUSH: begin
        if (req.event_class == CLS_UNSUP) begin
          res.status = ST_UNSUPPORTED;
        end else if (full) begin
          res.status = ST_FULL;
        end else begin
          push_ok        = 1'b1;
          free_depth_nxt = depth_dec;
          slot_we        = 1'b1;
          do_enq         = 1'b1;
          enq_kind       = push_kind;
          enq_slot       = push_slot;
        end
      end
      OP_BEGIN, OP_POP: begin
        if (busy_r) begin
          res.status = ST_CONFLICT;
        end else if (total_count_r == '0 || !sel_any) begin
          res.status = ST_EMPTY;
        end else begin
          case (sel_kind)
            KIND_URGENT: begin
              urg_rptr_nxt     = (urg_rptr_r == SW'(TOTAL_SLOTS - 1)) ?
                                 '0 : urg_rptr_r + SW'(1);
              urgent_count_nxt = urgent_count_r - TCW'(1);
            end
            KIND_STOP: begin
              stp_rptr_nxt   = (stp_rptr_r == SIW'(NONURGENT_SLOTS - 1)) ?
                               '0 : stp_rptr_r + SIW'(1);
              stop_count_nxt = stop_count_r - SCW'(1);
            end
            default: begin
              nrm_rptr_nxt     = (nrm_rptr_r == NIW'(NORMAL_SLOTS - 1)) ?
                                 '0 : nrm_rptr_r + NIW'(1);
              normal_count_nxt = normal_count_r - NCW'(1);
            end
          endcase
          res.out_payload     = slot_payload[sel_slot];
          res.out_length      = slot_length[sel_slot];
          res.out_received_ms = slot_time[sel_slot];
          res.out_class       = sel_class;
          free_slot           = sel_slot;
          if (expired) begin
            res.status = ST_EXPIRED;
            do_free    = 1'b1;
          end else if (req.opcode == OP_BEGIN) begin
            busy_nxt  = 1'b1;
            dkind_nxt = sel_kind;
            dslot_nxt = sel_slot;
          end else begin
            do_free = 1'b1;
          end
        end
      end
      OP_FINISH: begin
        if (!busy_r) begin
          res.status = ST_EMPTY;
        end else if (req.retry && dkind_r == KIND_NONE) begin
          res.status = ST_CONFLICT;
        end else begin
          if (req.retry) begin
            do_enq   = 1'b1;
            enq_kind = dkind_r;
            enq_slot = dslot_r;
          end else begin
            do_free   = 1'b1;
            free_slot = dslot_r;
          end
          busy_nxt  = 1'b0;
          dkind_nxt = KIND_NONE;
          dslot_nxt = '0;
        end
      end
      default: res.status = ST_OK;
    endcase

    if (push_ok) begin
      total_count_nxt = total_count_r + TCW'(1);
    end
    if (do_free) begin
      if (free_depth_r < TCW'(TOTAL_SLOTS)) begin
        fs_we          = 1'b1;
        fs_wd          = free_slot;
        free_depth_nxt = free_depth_r + TCW'(1);
      end
      if (total_count_r != '0) begin
        total_count_nxt = total_count_r - TCW'(1);
      end
    end
    if (do_enq) begin
      ring_wd = enq_slot;
      case (enq_kind)
        KIND_URGENT: begin
          u_we = 1'b1;
          if (urgent_count_r < TCW'(TOTAL_SLOTS)) begin
            urgent_count_nxt = urgent_count_r + TCW'(1);
          end
        end
        KIND_STOP: begin
          s_we = 1'b1;
          if (stop_count_r < SCW'(NONURGENT_SLOTS)) begin
            stop_count_nxt = stop_count_r + SCW'(1);
          end
        end
        default: begin
          n_we = 1'b1;
          if (normal_count_r < NCW'(NORMAL_SLOTS)) begin
            normal_count_nxt = normal_count_r + NCW'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_depth_r   <= TCW'(TOTAL_SLOTS);
      urg_rptr_r     <= '0;
      urgent_count_r <= '0;
      stp_rptr_r     <= '0;
      stop_count_r   <= '0;
      nrm_rptr_r     <= '0;
      normal_count_r <= '0;
      total_count_r  <= '0;
      busy_r         <= 1'b0;
      dkind_r        <= KIND_NONE;
      dslot_r        <= '0;
    end else if (step) begin
      free_depth_r   <= free_depth_nxt;
      urg_rptr_r     <= urg_rptr_nxt;
      urgent_count_r <= urgent_count_nxt;
      stp_rptr_r     <= stp_rptr_nxt;
      stop_count_r   <= stop_count_nxt;
      nrm_rptr_r     <= nrm_rptr_nxt;
      normal_count_r <= normal_count_nxt;
      total_count_r  <= total_count_nxt;
      busy_r         <= busy_nxt;
      dkind_r        <= dkind_nxt;
      dslot_r        <= dslot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOTAL_SLOTS; i++) begin
        free_stack_r[i] <= SW'(TOTAL_SLOTS - 1 - i);
      end
    end else if (step && fs_we) begin
      free_stack_r[fs_wa] <= fs_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (step && slot_we) begin
      slot_payload[slot_wa] <= req.payload;
      slot_length[slot_wa]  <= req.payload_length;
      slot_time[slot_wa]    <= req.time_ms;
    end
    if (step && u_we) urgent_ring[u_wa] <= ring_wd;
    if (step && s_we) stop_ring[s_wa]   <= ring_wd;
    if (step && n_we) normal_ring[n_wa] <= ring_wd;
  end

  a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
    int'(free_depth_r) + int'(total_count_r) == TOTAL_SLOTS)
    else $error("free depth and backlog count out of balance");

  a_class_balance: assert property (@(posedge clk) disable iff (!rst_n)
    int'(urgent_count_r) + int'(stop_count_r) + int'(normal_count_r)
      + int'(busy_r) == int'(total_count_r))
    else $error("class counts disagree with backlog count");

  a_busy_kind: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> dkind_r != KIND_NONE)
    else $error("dispatch active without a kind");

  a_nonurgent_cap: assert property (@(posedge clk) disable iff (!rst_n)
    step && req.opcode == OP_PUSH && res.status == ST_OK
      && req.event_class != CLS_URGENT |-> nonurg < NUW'(NONURGENT_SLOTS))
    else $error("non-urgent push accepted over cap");

endmodule

FILE: sim/tb_class_priority_event_backlog.sv
// ----------------------------------------------------------------------------
// tb_class_priority_event_backlog
// Self-checking bench for the three-class priority backlog. A directed table
// covers the empty, full, unsupported, conflict, expiry and retry paths. It is
// followed by random traffic in several phases with different sender and
// receiver idling and different max age settings. Every result transfer is
// checked against the table for typed rows, else against an in-bench model
// of the slot pool, the class rings and the dispatch register.
// ----------------------------------------------------------------------------
module tb_class_priority_event_backlog;
  import cpeb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_SLOTS     = 16;
  localparam int NONURGENT_SLOTS = 8;
  localparam int NORMAL_SLOTS    = 4;
  localparam int NUM_PHASES      = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;   // event_class, payload, payload_length, time_ms, retry
  logic [1:0]  in_tuser = '0;   // opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;       // out_payload, out_length, out_received_ms, out_class
  logic [2:0]  out_tuser;       // status
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  class_priority_event_backlog #(
    .TOTAL_SLOTS    (TOTAL_SLOTS),
    .NONURGENT_SLOTS(NONURGENT_SLOTS),
    .NORMAL_SLOTS   (NORMAL_SLOTS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // backlog model state
  logic [31:0] max_age;
  logic [31:0] pool_payload [TOTAL_SLOTS];
  logic [7:0]  pool_length  [TOTAL_SLOTS];
  logic [31:0] pool_time    [TOTAL_SLOTS];
  logic [3:0]  spare_stack  [TOTAL_SLOTS];
  int          free_top;
  logic [3:0]  urgent_q [TOTAL_SLOTS];
  logic [3:0]  stop_q   [NONURGENT_SLOTS];
  logic [3:0]  normal_q [NORMAL_SLOTS];
  int          urg_rptr, urgent_cnt;
  int          stp_rptr, stop_cnt;
  int          nrm_rptr, normal_cnt;
  int          jobs_total;
  bit          active;
  kind_t       active_kind;
  logic [3:0]  active_slot;

  res_t        pending_results [$];
  int          error_count = 0;

  // traffic shaping
  int          sender_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_seen = 1'b0;
  int          hold_left = 0;
  logic [31:0] clock_ms = '0;

  // directed table
  req_t        dir_req   [$];
  res_t        dir_want  [$];
  bit          dir_typed [$];

  int          phase_sender_pct [NUM_PHASES] = '{0, 82, 0, 35, 0, 0};
  int          phase_stall_pct  [NUM_PHASES] = '{0, 0, 82, 35, 0, 0};
  int          phase_push_pct   [NUM_PHASES] = '{55, 50, 60, 50, 70, 40};
  int          phase_items      [NUM_PHASES] = '{200, 200, 200, 200, 150, 150};
  logic [31:0] phase_max_age    [NUM_PHASES];

  function automatic void release_slot(input logic [3:0] slot);
    if (free_top < TOTAL_SLOTS) begin
      spare_stack[free_top] = slot;
      free_top++;
    end
    if (jobs_total > 0) jobs_total--;
  endfunction

  function automatic void append_job(input kind_t kind, input logic [3:0] slot);
    if (kind == KIND_URGENT) begin
      urgent_q[(urg_rptr + urgent_cnt) % TOTAL_SLOTS] = slot;
      if (urgent_cnt < TOTAL_SLOTS) urgent_cnt++;
    end else if (kind == KIND_STOP) begin
      stop_q[(stp_rptr + stop_cnt) % NONURGENT_SLOTS] = slot;
      if (stop_cnt < NONURGENT_SLOTS) stop_cnt++;
    end else begin
      normal_q[(nrm_rptr + normal_cnt) % NORMAL_SLOTS] = slot;
      if (normal_cnt < NORMAL_SLOTS) normal_cnt++;
    end
  endfunction

  function automatic status_t begin_job(input logic [31:0] now, output res_t taken);
    logic [3:0]  slot;
    kind_t       kind;
    logic [31:0] age;
    taken = '0;
    if (active) return ST_CONFLICT;
    if (jobs_total == 0) return ST_EMPTY;
    if (urgent_cnt != 0) begin
      kind = KIND_URGENT;
      taken.out_class = CLS_URGENT;
      slot = urgent_q[urg_rptr];
      urg_rptr = (urg_rptr + 1) % TOTAL_SLOTS;
      urgent_cnt--;
    end else if (stop_cnt != 0) begin
      kind = KIND_STOP;
      taken.out_class = CLS_STOP;
      slot = stop_q[stp_rptr];
      stp_rptr = (stp_rptr + 1) % NONURGENT_SLOTS;
      stop_cnt--;
    end else if (normal_cnt != 0) begin
      kind = KIND_NORMAL;
      taken.out_class = CLS_NORMAL;
      slot = normal_q[nrm_rptr];
      nrm_rptr = (nrm_rptr + 1) % NORMAL_SLOTS;
      normal_cnt--;
    end else begin
      return ST_EMPTY;
    end
    taken.out_payload     = pool_payload[slot];
    taken.out_length      = pool_length[slot];
    taken.out_received_ms = pool_time[slot];
    age = now - pool_time[slot];
    if (kind != KIND_URGENT && age > max_age) begin
      release_slot(slot);
      return ST_EXPIRED;
    end
    active_slot = slot;
    active_kind = kind;
    active = 1'b1;
    return ST_OK;
  endfunction

  function automatic status_t finish_job(input logic retry);
    if (!active) return ST_EMPTY;
    if (retry) begin
      if (active_kind == KIND_NONE) return ST_CONFLICT;
      append_job(active_kind, active_slot);
    end else begin
      release_slot(active_slot);
    end
    active_slot = '0;
    active_kind = KIND_NONE;
    active = 1'b0;
    return ST_OK;
  endfunction

  function automatic res_t backlog_outcome(input req_t job);
    res_t       r;
    res_t       taken;
    status_t    st;
    kind_t      kind;
    int         nonurgent;
    int         normal;
    logic [3:0] slot;
    taken = '0;
    case (job.opcode)
      OP_PUSH: begin
        if (job.event_class == CLS_UNSUP) begin
          st = ST_UNSUPPORTED;
        end else begin
          kind = (job.event_class == CLS_URGENT) ? KIND_URGENT :
                 (job.event_class == CLS_STOP) ? KIND_STOP : KIND_NORMAL;
          nonurgent = stop_cnt + normal_cnt + ((active && active_kind != KIND_URGENT) ? 1 : 0);
          normal = normal_cnt + ((active && active_kind == KIND_NORMAL) ? 1 : 0);
          if (jobs_total >= TOTAL_SLOTS || free_top == 0 ||
              (kind != KIND_URGENT && nonurgent >= NONURGENT_SLOTS) ||
              (kind == KIND_NORMAL && normal >= NORMAL_SLOTS)) begin
            st = ST_FULL;
          end else begin
            free_top--;
            slot = spare_stack[free_top];
            pool_payload[slot] = job.payload;
            pool_length[slot]  = job.payload_length;
            pool_time[slot]    = job.time_ms;
            append_job(kind, slot);
            jobs_total++;
            st = ST_OK;
          end
        end
      end
      OP_BEGIN:  st = begin_job(job.time_ms, taken);
      OP_FINISH: st = finish_job(job.retry);
      default: begin
        st = begin_job(job.time_ms, taken);
        if (st == ST_OK) st = finish_job(1'b0);
      end
    endcase
    r = (st == ST_OK || st == ST_EXPIRED) ? taken : '0;
    r.status = st;
    return r;
  endfunction

  task automatic add_row(input opcode_t op, input logic [1:0] cls, input logic [31:0] pl,
                         input logic [7:0] len, input logic [31:0] tms, input logic rt,
                         input bit typed, input status_t st, input logic [31:0] xp,
                         input logic [7:0] xl, input logic [31:0] xt, input logic [1:0] xc);
    req_t q;
    res_t w;
    q.opcode = op;
    q.event_class = cls;
    q.payload = pl;
    q.payload_length = len;
    q.time_ms = tms;
    q.retry = rt;
    w.status = st;
    w.out_payload = xp;
    w.out_length = xl;
    w.out_received_ms = xt;
    w.out_class = xc;
    dir_req.push_back(q);
    dir_want.push_back(w);
    dir_typed.push_back(typed);
  endtask

  task automatic send_job(input req_t job, input bit typed, input res_t want);
    res_t outcome;
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= job.opcode;
    in_tdata  <= {5'b0, job.retry, job.time_ms, job.payload_length, job.payload,
                  job.event_class};
    do @(posedge clk); while (!in_tready);
    outcome = backlog_outcome(job);
    pending_results.push_back(typed ? want : outcome);
  endtask

  task automatic write_max_age(input logic [31:0] value);
    while (pending_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    max_age = value;
  endtask

  // result side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer, status %0d payload %0h",
                 $time, out_tuser, out_tdata[31:0]);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_tuser));
        check_field("out_payload", want.out_payload, out_tdata[31:0]);
        check_field("out_length", 32'(want.out_length), 32'(out_tdata[39:32]));
        check_field("out_received_ms", want.out_received_ms, out_tdata[71:40]);
        check_field("out_class", 32'(want.out_class), 32'(out_tdata[73:72]));
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    req_t job;
    res_t none;
    int   pick;
    int   rest;

    none = '0;
    max_age = MAX_AGE_RESET;
    for (int i = 0; i < TOTAL_SLOTS; i++) spare_stack[i] = 4'(TOTAL_SLOTS - 1 - i);
    free_top = TOTAL_SLOTS;
    urg_rptr = 0; urgent_cnt = 0;
    stp_rptr = 0; stop_cnt = 0;
    nrm_rptr = 0; normal_cnt = 0;
    jobs_total = 0;
    active = 1'b0;
    active_kind = KIND_NONE;
    active_slot = '0;

    phase_max_age[0] = MAX_AGE_RESET;
    phase_max_age[1] = 32'd0;
    phase_max_age[2] = 32'hFFFF_FFFF;
    phase_max_age[3] = $urandom_range(4000);
    phase_max_age[4] = 32'd300;
    phase_max_age[5] = 32'd5000;

    // op, class, payload, length, time, retry, typed, expected status and job fields
    add_row(OP_FINISH, CLS_URGENT, 0, 0, 0, 1'b0, 1, ST_EMPTY, 0, 0, 0, 0);
    add_row(OP_BEGIN, CLS_URGENT, 0, 0, 0, 1'b0, 1, ST_EMPTY, 0, 0, 0, 0);
    add_row(OP_POP, CLS_URGENT, 0, 0, 0, 1'b0, 1, ST_EMPTY, 0, 0, 0, 0);
    add_row(OP_PUSH, CLS_UNSUP, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1,
            ST_UNSUPPORTED, 0, 0, 0, 0);
    add_row(OP_PUSH, CLS_URGENT, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b0, 1,
            ST_OK, 0, 0, 0, 0);
    add_row(OP_PUSH, CLS_STOP, 0, 0, 0, 1'b0, 1, ST_OK, 0, 0, 0, 0);
    add_row(OP_PUSH, CLS_NORMAL, 32'hA5A5_A5A5, 8'h80, 32'd100, 1'b0, 1, ST_OK, 0, 0, 0, 0);
    add_row(OP_BEGIN, CLS_URGENT, 0, 0, 0, 1'b0, 1,
            ST_OK, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, CLS_URGENT);
    add_row(OP_BEGIN, CLS_URGENT, 0, 0, 1, 1'b0, 1, ST_CONFLICT, 0, 0, 0, 0);
    add_row(OP_POP, CLS_URGENT, 0, 0, 2, 1'b0, 1, ST_CONFLICT, 0, 0, 0, 0);
    add_row(OP_FINISH, CLS_URGENT, 0, 0, 3, 1'b1, 1, ST_OK, 0, 0, 0, 0);
    add_row(OP_POP, CLS_URGENT, 0, 0, 5, 1'b0, 1,
            ST_OK, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, CLS_URGENT);
    // stop job is 2000 ms old: expires
    add_row(OP_BEGIN, CLS_URGENT, 0, 0, 2000, 1'b0, 1, ST_EXPIRED, 0, 0, 0, CLS_STOP);
    // normal job exactly at the age limit: still dispatched
    add_row(OP_POP, CLS_URGENT, 0, 0, 1100, 1'b0, 1,
            ST_OK, 32'hA5A5_A5A5, 8'h80, 32'd100, CLS_NORMAL);
    add_row(OP_PUSH, CLS_NORMAL, 32'h1234_5678, 8'h01, 32'hFFFF_FFF0, 1'b0, 0, ST_OK, 0, 0, 0, 0);
    add_row(OP_PUSH, CLS_NORMAL, 32'h8765_4321, 8'h7F, 32'hFFFF_FFF0, 1'b1, 0, ST_OK, 0, 0, 0, 0);
    add_row(OP_PUSH, CLS_NORMAL, 32'h5A5A_5A5A, 8'hFE, 32'hFFFF_FFF8, 1'b0, 0, ST_OK, 0, 0, 0, 0);
    add_row(OP_PUSH, CLS_NORMAL, 32'h0F0F_0F0F, 8'h10, 32'hFFFF_FFFF, 1'b0, 0, ST_OK, 0, 0, 0, 0);
    add_row(OP_PUSH, CLS_NORMAL, 32'hDEAD_BEEF, 8'h22, 32'd20, 1'b0, 1, ST_FULL, 0, 0, 0, 0);
    // dispatch time wrapped past zero
    add_row(OP_BEGIN, CLS_URGENT, 0, 0, 32'd10, 1'b0, 0, ST_OK, 0, 0, 0, 0);
    add_row(OP_PUSH, CLS_NORMAL, 32'hCAFE_0001, 8'h33, 32'd12, 1'b0, 1, ST_FULL, 0, 0, 0, 0);
    add_row(OP_FINISH, CLS_URGENT, 0, 0, 32'd14, 1'b1, 1, ST_OK, 0, 0, 0, 0);
    add_row(OP_PUSH, CLS_STOP, 32'h0000_FFFF, 8'h44, 32'd15, 1'b0, 0, ST_OK, 0, 0, 0, 0);
    add_row(OP_FINISH, CLS_URGENT, 0, 0, 32'd16, 1'b0, 1, ST_EMPTY, 0, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_req[i]) send_job(dir_req[i], dir_typed[i], dir_want[i]);
    in_tvalid <= 1'b0;
    clock_ms = 32'd100;

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_max_age(phase_max_age[p]);
      sender_idle_pct = phase_sender_pct[p];
      stall_pct = phase_stall_pct[p];
      for (int n = 0; n < phase_items[p]; n++) begin
        if (p == 4 && n == 0) hold_req = ~hold_req;
        if (p == 4 && n == 75) begin
          in_tvalid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
        clock_ms = ($urandom_range(49) == 0) ? $urandom() : clock_ms + $urandom_range(200);
        job.payload = $urandom();
        job.payload_length = 8'($urandom_range(255));
        job.retry = 1'($urandom_range(1));
        job.event_class = ($urandom_range(15) == 0) ? CLS_UNSUP : 2'($urandom_range(2));
        job.time_ms = clock_ms;
        pick = $urandom_range(99);
        rest = (100 - phase_push_pct[p]) / 3;
        if (pick < phase_push_pct[p]) begin
          job.opcode = OP_PUSH;
          if ($urandom_range(3) == 0) job.time_ms = clock_ms - $urandom_range(2000);
        end else if (pick < phase_push_pct[p] + rest) begin
          job.opcode = OP_BEGIN;
        end else if (pick < phase_push_pct[p] + 2 * rest) begin
          job.opcode = OP_FINISH;
        end else begin
          job.opcode = OP_POP;
        end
        send_job(job, 1'b0, none);
      end
      in_tvalid <= 1'b0;
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
